FILE: rtl/ccsr_pkg.sv
package ccsr_pkg;

  localparam int unsigned Slots        = 16;
  localparam int unsigned SlotW        = $clog2(Slots);
  localparam int unsigned PosW         = 64;
  localparam int unsigned MsgStateSize = 4;
  localparam int unsigned StrideW      = 17;
  localparam int unsigned OffsetW      = 20;
  localparam int unsigned OccW         = 5;
  localparam int unsigned GrantW       = 4;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned StepW        = 5;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic MsgStateFree = 1'b0;
  localparam logic MsgStateBusy = 1'b1;

  typedef enum logic [2:0] {
    CMD_CLAIM       = 3'd0,
    CMD_COMMIT_SLOT = 3'd1,
    CMD_CLAIM_READ  = 3'd2,
    CMD_COMMIT_READ = 3'd3,
    CMD_READ_ONE    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_PENDING = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRODUCER_MODE = 2'd0,
    CFG_LOOK_AHEAD    = 2'd1,
    CFG_MSG_BYTES     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic               multi_mode;
    logic [StepW-1:0]   step;
    logic [StrideW-1:0] stride;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr_a;
    logic [SlotW-1:0] rd_addr_b;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic             wr_data;
  } ram_req_t;

  // a <= b in wrapping position order
  function automatic logic pos_le(logic [PosW-1:0] a, logic [PosW-1:0] b);
    logic [PosW-1:0] d;
    d = b - a;
    return ~d[PosW-1];
  endfunction

endpackage

FILE: rtl/ccsr_flag_ram.sv
module ccsr_flag_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccsr_pkg::ram_req_t req_i,
  output logic              rd_a_o,
  output logic              rd_b_o
);
  import ccsr_pkg::*;

  logic             mem_q [Slots];
  logic [Slots-1:0] valid_q;
  logic             rd_a_q;
  logic             rd_b_q;

  // Busy flags; an entry never written reads as free.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q <= valid_q[req_i.rd_addr_a] ? mem_q[req_i.rd_addr_a] : MsgStateFree;
      rd_b_q <= valid_q[req_i.rd_addr_b] ? mem_q[req_i.rd_addr_b] : MsgStateFree;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

FILE: rtl/ccsr_engine.sv
module ccsr_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccsr_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   command_i,
  input  logic [ccsr_pkg::IdxW-1:0]    slot_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [ccsr_pkg::GrantW-1:0]  granted_slot_o,
  output logic [ccsr_pkg::OffsetW-1:0] payload_offset_o,
  output logic [ccsr_pkg::OccW-1:0]    occupancy_o,
  output logic                         is_empty_o,
  output ccsr_pkg::ram_req_t           ram_req_o,
  input  logic                         rd_a_i,
  input  logic                         rd_b_i
);
  import ccsr_pkg::*;

  state_e state_q, state_d;

  logic [PosW-1:0] prod_q, prod_d;
  logic [PosW-1:0] cons_q, cons_d;
  logic [PosW-1:0] cache_q, cache_d;
  logic [PosW-1:0] next_q;
  logic [PosW-1:0] wrap_q;
  logic [2:0]      cmd_q;
  logic [SlotW-1:0] idx_q;

  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [GrantW-1:0]  grant_q, grant_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [OccW-1:0]    occ_q, occ_d;
  logic               empty_q, empty_d;

  logic              accept;
  logic              exec_go;
  logic              grant;
  logic [SlotW-1:0]  slot;
  logic [PosW-1:0]   cache_next;
  logic [OffsetW-1:0] product;

  assign accept  = in_valid_i && in_ready_o;
  assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    cache_next = cache_q + PosW'(cfg_i.step);
  end

  // Issue flag reads at accept: port A is the look-ahead or consumer slot,
  // port B the producer slot.
  always_comb begin
    ram_req_o           = '0;
    ram_req_o.rd_en     = accept;
    ram_req_o.rd_addr_a = (cmd_e'(command_i) == CMD_CLAIM) ? cache_next[SlotW-1:0]
                                                           : cons_q[SlotW-1:0];
    ram_req_o.rd_addr_b = prod_q[SlotW-1:0];
    ram_req_o.wr_addr   = idx_q;
    ram_req_o.wr_data   = MsgStateBusy;

    state_d  = state_q;
    prod_d   = prod_q;
    cons_d   = cons_q;
    cache_d  = cache_q;
    status_d = STS_OK;
    grant    = 1'b0;
    slot     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
          case (cmd_e'(cmd_q))
            CMD_CLAIM: begin
              grant = 1'b1;
              if (!cfg_i.multi_mode) begin
                if (pos_le(cache_q, prod_q)) begin
                  if (rd_a_i == MsgStateFree) begin
                    cache_d = next_q;
                  end else if (rd_b_i != MsgStateFree) begin
                    grant = 1'b0;
                  end
                end
              end else if (pos_le(cache_q, wrap_q)) begin
                if (pos_le(cons_q, wrap_q)) begin
                  grant = 1'b0;
                end else begin
                  cache_d = cons_q;
                end
              end
              if (grant) begin
                slot   = prod_q[SlotW-1:0];
                prod_d = prod_q + PosW'(1);
              end else begin
                status_d = STS_FULL;
              end
            end
            CMD_COMMIT_SLOT: begin
              ram_req_o.wr_en = 1'b1;
            end
            CMD_CLAIM_READ, CMD_READ_ONE: begin
              if (rd_a_i == MsgStateFree) begin
                status_d = (prod_q == cons_q) ? STS_EMPTY : STS_PENDING;
              end else begin
                ram_req_o.wr_en   = 1'b1;
                ram_req_o.wr_addr = cons_q[SlotW-1:0];
                ram_req_o.wr_data = MsgStateFree;
                grant             = 1'b1;
                slot              = cons_q[SlotW-1:0];
                if (cmd_e'(cmd_q) == CMD_READ_ONE) begin
                  cons_d = cons_q + PosW'(1);
                end
              end
            end
            CMD_COMMIT_READ: begin
              if (prod_q == cons_q) begin
                status_d = STS_EMPTY;
              end else begin
                cons_d = cons_q + PosW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase

    product  = OffsetW'(slot) * OffsetW'(cfg_i.stride);
    grant_d  = grant ? GrantW'(slot) : '0;
    offset_d = grant ? (product + OffsetW'(MsgStateSize)) : '0;
    occ_d    = prod_d[OccW-1:0] - cons_d[OccW-1:0];
    empty_d  = (prod_d == cons_d);
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prod_q      <= '0;
      cons_q      <= '0;
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prod_q  <= prod_d;
      cons_q  <= cons_d;
      cache_q <= cache_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      idx_q  <= SlotW'(slot_index_i);
      next_q <= cache_next;
      wrap_q <= prod_q - PosW'(Slots);
    end
    if (exec_go) begin
      status_q <= status_d;
      grant_q  <= grant_d;
      offset_q <= offset_d;
      occ_q    <= occ_d;
      empty_q  <= empty_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_slot_o   = grant_q;
  assign payload_offset_o = offset_q;
  assign occupancy_o      = occ_q;
  assign is_empty_o       = empty_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted transaction did not enter execute");

  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |=> $stable(prod_q) && $stable(cons_q))
    else $error("positions moved without a transaction");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != STS_OK |-> grant_q == '0 && offset_q == '0)
    else $error("slot fields set on a failed transaction");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty_q |-> occ_q == '0)
    else $error("empty ring reports occupancy");

  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wr_en |-> exec_go)
    else $error("flag write outside execute");

endmodule

FILE: rtl/claim_commit_slot_ring.sv
// Channel  Direction  Handshake                Payload
// cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o    command_i, slot_index_i
// out      out        out_valid_o/out_ready_i  status_o, granted_slot_o, payload_offset_o,
//                                              occupancy_o, is_empty_o
//
// Each command reads the busy-flag memory at accept (registered read, two read
// ports), then evaluates, writes back a flag and updates the positions in the
// execute state. A new transaction is accepted only after the last has executed.
// Reset (rst_ni low, asynchronous) clears positions, flag valid bits and
// config to mode 0, look-ahead 4, 60 payload bytes; no clearing pass.
// The result sits in an output register; one more command is accepted while
// it waits, and execution holds until the output register is taken.
// Config writes are always ready and must come only while the ring is idle.
module claim_commit_slot_ring (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ccsr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ccsr_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          command_i,
  input  logic [ccsr_pkg::IdxW-1:0]           slot_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [ccsr_pkg::GrantW-1:0]         granted_slot_o,
  output logic [ccsr_pkg::OffsetW-1:0]        payload_offset_o,
  output logic [ccsr_pkg::OccW-1:0]           occupancy_o,
  output logic                                is_empty_o
);
  import ccsr_pkg::*;

  logic                mode_q;
  logic [StepW-1:0]    step_q;
  logic [CfgDataW-1:0] msg_bytes_q;
  logic [StrideW-1:0]  stride_sum;
  cfg_t                cfg;
  ram_req_t            ram_req;
  logic                rd_a;
  logic                rd_b;

  assign cfg_ready_o = 1'b1;

  // Config registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      step_q      <= StepW'(4);
      msg_bytes_q <= CfgDataW'(60);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRODUCER_MODE: mode_q      <= cfg_data_i[0];
        CFG_LOOK_AHEAD:    step_q      <= cfg_data_i[StepW-1:0];
        CFG_MSG_BYTES:     msg_bytes_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Slot stride: payload plus the state word, rounded up to four bytes.
  assign stride_sum = StrideW'(msg_bytes_q) + StrideW'(MsgStateSize + 3);

  always_comb begin
    cfg            = '0;
    cfg.multi_mode = mode_q;
    cfg.step       = step_q;
    cfg.stride     = {stride_sum[StrideW-1:2], 2'b00};
  end

  ccsr_flag_ram u_flag_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  ccsr_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .payload_offset_o (payload_offset_o),
    .occupancy_o      (occupancy_o),
    .is_empty_o       (is_empty_o),
    .ram_req_o        (ram_req),
    .rd_a_i           (rd_a),
    .rd_b_i           (rd_b)
  );

endmodule

FILE: tb/claim_commit_slot_ring_tb.sv
`timescale 1ns / 1ps

module claim_commit_slot_ring_tb;
  import ccsr_pkg::*;

  // Command code outside the defined set; the block must leave the ring alone
  localparam logic [2:0] CmdUnused = 3'd7;

  localparam int unsigned PhaseItems = 264;
  localparam int unsigned Phases     = 7;

  typedef struct packed {
    status_e             status;
    logic [GrantW-1:0]   slot;
    logic [OffsetW-1:0]  offset;
    logic [OccW-1:0]     occ;
    logic                empty;
  } ring_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One directed step: either a command (repeated reps times) or a register write.
  // When typed_in is set, want is the expected result; otherwise the predictor decides.
  typedef struct packed {
    row_kind_e         kind;
    logic [2:0]        cmd;
    logic [IdxW-1:0]   idx;
    logic [4:0]        reps;
    logic              typed_in;
    ring_result_t      want;
    cfg_idx_e          cfg_sel;
    logic [CfgDataW-1:0] cfg_val;
  } script_row_t;

  typedef struct packed {
    logic                multi;
    logic [StepW-1:0]    step;
    logic [CfgDataW-1:0] bytes;
  } ring_cfg_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = CFG_PRODUCER_MODE;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [2:0]          command_i    = CMD_CLAIM;
  logic [IdxW-1:0]     slot_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [1:0]          status_o;
  logic [GrantW-1:0]   granted_slot_o;
  logic [OffsetW-1:0]  payload_offset_o;
  logic [OccW-1:0]     occupancy_o;
  logic                is_empty_o;

  claim_commit_slot_ring DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .payload_offset_o (payload_offset_o),
    .occupancy_o      (occupancy_o),
    .is_empty_o       (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Ring shadow: busy flags, positions and register copy, updated per command
  // in the order the block accepts them.
  // ---------------------------------------------------------------------------
  logic              busy_flag [Slots];
  logic [PosW-1:0]   prod_pos  = '0;
  logic [PosW-1:0]   cons_pos  = '0;
  logic [PosW-1:0]   cons_hint = '0;
  logic              multi_mode = 1'b0;
  logic [StepW-1:0]  probe_step = 5'd4;
  logic [CfgDataW-1:0] msg_bytes = 16'd60;

  initial foreach (busy_flag[i]) busy_flag[i] = MsgStateFree;

  // Expected results, oldest first. An entry is pushed when its command is
  // put on the bus; the monitor only pops entries whose command was accepted.
  ring_result_t expected_results [$];
  int unsigned  accepted_items  = 0;
  int unsigned  checked_results = 0;
  int unsigned  mismatches      = 0;
  bit           steady          = 1'b0;   // high: no idling on either side

  // a is at or behind b in free-running position order
  function automatic logic pos_not_after(logic [PosW-1:0] a, logic [PosW-1:0] b);
    logic [PosW-1:0] diff;
    diff = b - a;
    return ~diff[PosW-1];
  endfunction

  function automatic ring_result_t predict_ring_result(logic [2:0] cmd, logic [IdxW-1:0] idx);
    ring_result_t     res;
    logic [PosW-1:0]  probe_pos;
    logic [PosW-1:0]  wrap_pos;
    logic [SlotW-1:0] head;
    logic [31:0]      stride;
    logic             room;
    logic             grant;
    res    = '0;
    res.status = STS_OK;
    grant  = 1'b0;
    room   = 1'b1;
    head   = '0;
    case (cmd)
      CMD_CLAIM: begin
        if (!multi_mode) begin
          // Single producer: look ahead of the cached consumer position
          if (pos_not_after(cons_hint, prod_pos)) begin
            probe_pos = cons_hint + PosW'(probe_step);
            if (busy_flag[probe_pos[SlotW-1:0]] == MsgStateFree) begin
              cons_hint = probe_pos;
            end else if (busy_flag[prod_pos[SlotW-1:0]] != MsgStateFree) begin
              room = 1'b0;
            end
          end
        end else begin
          // Multi producer: full once the consumer sits a whole ring behind
          wrap_pos = prod_pos - PosW'(Slots);
          if (pos_not_after(cons_hint, wrap_pos)) begin
            if (pos_not_after(cons_pos, wrap_pos)) room = 1'b0;
            else cons_hint = cons_pos;
          end
        end
        if (room) begin
          head  = prod_pos[SlotW-1:0];
          prod_pos = prod_pos + 1;
          grant = 1'b1;
        end else begin
          res.status = STS_FULL;
        end
      end
      CMD_COMMIT_SLOT: busy_flag[idx[SlotW-1:0]] = MsgStateBusy;
      CMD_CLAIM_READ, CMD_READ_ONE: begin
        head = cons_pos[SlotW-1:0];
        if (busy_flag[head] == MsgStateFree) begin
          res.status = (prod_pos == cons_pos) ? STS_EMPTY : STS_PENDING;
        end else begin
          busy_flag[head] = MsgStateFree;
          if (cmd == CMD_READ_ONE) cons_pos = cons_pos + 1;
          grant = 1'b1;
        end
      end
      CMD_COMMIT_READ: begin
        if (prod_pos == cons_pos) res.status = STS_EMPTY;
        else cons_pos = cons_pos + 1;
      end
      default: ;
    endcase
    if (grant) begin
      stride     = (32'(msg_bytes) + MsgStateSize + 3) & ~32'd3;
      res.slot   = GrantW'(head);
      res.offset = OffsetW'(32'(head) * stride + MsgStateSize);
    end
    res.occ   = OccW'(prod_pos - cons_pos);
    res.empty = (prod_pos == cons_pos);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, checked_results, msg);
    mismatches++;
  endtask

  // Put one command on the bus after a random gap, record its expected
  // result, and return once the block has taken it. Valid stays high on
  // return; the caller drives the next command or drops valid.
  task automatic send_item(input logic [2:0] cmd, input logic [IdxW-1:0] idx,
                           input logic typed_in, input ring_result_t want,
                           output ring_result_t predicted);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predicted = predict_ring_result(cmd, idx);
    expected_results.push_back(typed_in ? want : predicted);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    slot_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Register writes only go out with the ring drained.
  task automatic write_register(input cfg_idx_e sel, input logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      CFG_PRODUCER_MODE: multi_mode = val[0];
      CFG_LOOK_AHEAD:    probe_step = val[StepW-1:0];
      CFG_MSG_BYTES:     msg_bytes  = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: count accepted commands, check each accepted result against the
  // oldest expectation, and throttle the result side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ring_result_t want;
    ring_result_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) accepted_items++;
      if (out_valid_o && out_ready_i) begin
        seen = '{status_e'(status_o), granted_slot_o, payload_offset_o, occupancy_o,
                 is_empty_o};
        if (checked_results >= accepted_items) begin
          report_mismatch($sformatf("result with no command outstanding (status %0d)",
                                    status_o));
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, want.status));
          if (seen.slot !== want.slot)
            report_mismatch($sformatf("granted_slot %0d, expected %0d", seen.slot, want.slot));
          if (seen.offset !== want.offset)
            report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                      seen.offset, want.offset));
          if (seen.occ !== want.occ)
            report_mismatch($sformatf("occupancy %0d, expected %0d", seen.occ, want.occ));
          if (seen.empty !== want.empty)
            report_mismatch($sformatf("is_empty %0d, expected %0d", seen.empty, want.empty));
          checked_results++;
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= 36);
  end

  // ---------------------------------------------------------------------------
  // Directed script. Starts from reset: mode single, look-ahead 4, 60 bytes.
  // ---------------------------------------------------------------------------
  script_row_t directed_script [14] = '{
    // empty ring: read one and commit read report empty
    '{ROW_ITEM, CMD_READ_ONE, 4'd0, 5'd1, 1'b1,
      '{STS_EMPTY, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    '{ROW_ITEM, CMD_COMMIT_READ, 4'd0, 5'd1, 1'b1,
      '{STS_EMPTY, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    // undefined command: no effect
    '{ROW_ITEM, CmdUnused, 4'd15, 5'd1, 1'b1,
      '{STS_OK, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    // publish the probe slot and the producer slot ahead of any claim
    '{ROW_ITEM, CMD_COMMIT_SLOT, 4'd4, 5'd1, 1'b1,
      '{STS_OK, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    '{ROW_ITEM, CMD_COMMIT_SLOT, 4'd0, 5'd1, 1'b1,
      '{STS_OK, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    // single producer: probe slot busy and producer slot busy -> full
    '{ROW_ITEM, CMD_CLAIM, 4'd9, 5'd1, 1'b1,
      '{STS_FULL, 4'd0, 20'd0, 5'd0, 1'b1}, CFG_PRODUCER_MODE, 16'd0},
    // read a published slot on an empty ring, then claim the freed slot
    '{ROW_ITEM, CMD_CLAIM_READ, 4'd6, 5'd1, 1'b0, '0, CFG_PRODUCER_MODE, 16'd0},
    '{ROW_ITEM, CMD_CLAIM, 4'd3, 5'd1, 1'b0, '0, CFG_PRODUCER_MODE, 16'd0},
    // claimed but never committed: not-ready status
    '{ROW_ITEM, CMD_CLAIM_READ, 4'd0, 5'd1, 1'b1,
      '{STS_PENDING, 4'd0, 20'd0, 5'd1, 1'b0}, CFG_PRODUCER_MODE, 16'd0},
    // multi producer with the widest look-ahead and largest stride this bench draws
    '{ROW_CFG, CMD_CLAIM, 4'd0, 5'd0, 1'b0, '0, CFG_PRODUCER_MODE, 16'd1},
    '{ROW_CFG, CMD_CLAIM, 4'd0, 5'd0, 1'b0, '0, CFG_LOOK_AHEAD, 16'd16},
    '{ROW_CFG, CMD_CLAIM, 4'd0, 5'd0, 1'b0, '0, CFG_MSG_BYTES, 16'd65532},
    // fill the ring up to slot 15, then the wrap check refuses
    '{ROW_ITEM, CMD_CLAIM, 4'd15, 5'd15, 1'b0, '0, CFG_PRODUCER_MODE, 16'd0},
    '{ROW_ITEM, CMD_CLAIM, 4'd0, 5'd1, 1'b1,
      '{STS_FULL, 4'd0, 20'd0, 5'd16, 1'b0}, CFG_PRODUCER_MODE, 16'd0}
  };

  // Register settings per random phase; later phases draw their own.
  ring_cfg_t phase_presets [5] = '{
    '{1'b0, 5'd4,  16'd60},
    '{1'b0, 5'd0,  16'd1},
    '{1'b1, 5'd16, 16'd65532},
    '{1'b0, 5'd15, 16'd4095},
    '{1'b1, 5'd1,  16'd2}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    script_row_t     row;
    ring_result_t    got_pred;
    ring_cfg_t       phase_cfg;
    logic [2:0]      cmd;
    logic [IdxW-1:0] idx;
    logic [PosW-1:0] commit_cursor;
    int unsigned     pick;
    int unsigned     item_no;
    bit              read_open;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_script[i]) begin
      row = directed_script[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.cfg_sel, row.cfg_val);
      end else begin
        repeat (row.reps) send_item(row.cmd, row.idx, row.typed_in, row.want, got_pred);
      end
    end

    // Random part: mostly claim / commit / read flows in producer order, with
    // a slice of arbitrary commands that break the flow.
    commit_cursor = cons_pos;
    read_open     = 1'b0;
    item_no       = 0;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph < 5) begin
        phase_cfg = phase_presets[ph];
      end else begin
        phase_cfg.multi = 1'($urandom_range(1));
        phase_cfg.step  = StepW'($urandom_range(16));
        phase_cfg.bytes = CfgDataW'($urandom_range(65532, 1));
      end
      write_register(CFG_PRODUCER_MODE, CfgDataW'(phase_cfg.multi));
      write_register(CFG_LOOK_AHEAD, CfgDataW'(phase_cfg.step));
      write_register(CFG_MSG_BYTES, phase_cfg.bytes);
      read_open = 1'b0;

      for (int n = 0; n < PhaseItems; n++) begin
        steady = (item_no >= 600 && item_no < 900);
        idx    = IdxW'($urandom_range(15));
        if ($urandom_range(99) < 12) begin
          cmd = 3'($urandom_range(7));
        end else if (read_open) begin
          cmd = CMD_COMMIT_READ;
        end else begin
          // Never commit behind the consumer
          if (commit_cursor != cons_pos && pos_not_after(commit_cursor, cons_pos))
            commit_cursor = cons_pos;
          pick = $urandom_range(99);
          if (pick < 34) begin
            cmd = CMD_CLAIM;
          end else if (pick < 67 && commit_cursor != prod_pos &&
                       pos_not_after(commit_cursor, prod_pos)) begin
            cmd = CMD_COMMIT_SLOT;
            idx = commit_cursor[SlotW-1:0];
            commit_cursor = commit_cursor + 1;
          end else if (prod_pos != cons_pos) begin
            cmd = $urandom_range(1) ? CMD_READ_ONE : CMD_CLAIM_READ;
          end else begin
            cmd = CMD_CLAIM;
          end
        end
        send_item(cmd, idx, 1'b0, '0, got_pred);
        read_open = (cmd == CMD_CLAIM_READ && got_pred.status == STS_OK);
        item_no++;
      end
    end
    steady = 1'b0;

    // Drop valid, drain, and give any stray result time to show up
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
